// ===== design/bbi_pkg.sv =====
// Shared types and constants for the ball bounce integrator.
`default_nettype none

package bbi_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GRAV_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BALL_RADIUS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_X     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y     = 3'd6;

  localparam logic signed [31:0] GRAV_RESET       = 32'sd0;
  localparam logic [30:0]        BOX_WIDTH_RESET  = 31'd52428800;
  localparam logic [30:0]        BOX_HEIGHT_RESET = 31'd39321600;
  localparam logic [30:0]        RADIUS_RESET     = 31'd655360;
  localparam logic signed [31:0] START_X_RESET    = 32'sd6553600;
  localparam logic signed [31:0] START_Y_RESET    = 32'sd6553600;
  localparam logic signed [31:0] VEL_X_RESET      = 32'sd1310720;
  localparam logic signed [31:0] VEL_Y_RESET      = 32'sd0;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // clamp on g*dh, 2^61
  localparam logic signed [65:0] GD_LIMIT = 66'sd2305843009213693952;

  localparam logic [4:0] SQ_LAST = 5'd31;

  typedef enum logic [4:0] {
    S_IDLE,
    S_VX_M,
    S_VX_A,
    S_VY_M,
    S_VY_A,
    S_PX_M,
    S_PX_A,
    S_PY_M,
    S_PY_A,
    S_CHK,
    S_DH,
    S_M0,
    S_M1,
    S_A1,
    S_CL,
    S_M3,
    S_A3,
    S_SQI,
    S_SQ,
    S_WB,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== design/ball_bounce_integrator.sv =====
// Ball bounce integrator top level: sequenced Euler step with wall bounce.
//
// Usage: each transfer on the step channel (step_valid, step_stall, step_time)
// advances the ball by one time step. One result transfer on the result
// channel (result_valid, result_stall, pos/vel/hit) follows each step.
// step_stall is high while a step is in work. The four dt products run
// on the shared 32x18 multiplier, each as a multiply and an add state;
// each axis then gets a wall check, and when it bounces, multiplies for
// 2*g*dh + v^2 and a square root of 32 root bits, each from two radicand
// bits, give the new speed. Steps do not overlap: a new step is taken in
// the cycle after the result register is loaded. The result register
// holds while result_valid and result_stall are both high; a finished
// step waits for it before the next step is taken.
// Configuration: cfg_we writes register cfg_index with cfg_data at once;
// a write of start_x or start_y also moves the ball there.
// Reset (rst, synchronous) loads default registers, the start position,
// velocity (20.0, 0) and empties the result register.
`default_nettype none

module ball_bounce_integrator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [bbi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data,
  input  wire logic                          step_valid,
  output logic                               step_stall,
  input  wire logic [15:0]                   step_time,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic signed [31:0]                 pos_x,
  output logic signed [31:0]                 pos_y,
  output logic signed [31:0]                 vel_x,
  output logic signed [31:0]                 vel_y,
  output logic                               hit_x,
  output logic                               hit_y
);

  bbi_pkg::state_t state, state_next;

  logic signed [31:0] grav_x, grav_y;
  logic [30:0]        box_width, box_height, ball_radius;
  logic signed [31:0] position_x, position_y, velocity_x, velocity_y;

  logic [15:0]        dt_r;
  logic               axis;
  logic               hit_x_r, hit_y_r, low_r;
  logic signed [31:0] np_r, vr_r;
  logic signed [32:0] dh_r;
  logic signed [49:0] prod_r;
  logic signed [65:0] acc;
  logic [63:0]        rad;
  logic [33:0]        rem;
  logic [31:0]        root;
  logic [4:0]         sq_cnt;

  logic signed [31:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [49:0] prod_next;
  logic               out_load;

  logic signed [31:0] ax_pos, ax_vel, ax_g, scale_base, scaled_q;
  logic [30:0]        ax_bound;
  logic signed [65:0] scaled_sum, prod_ext, acc_cl;
  logic signed [32:0] p_plus_r, dh_next;
  logic signed [31:0] bound_minus_r, vr_neg, vel_wb;
  logic               low, high;
  logic [35:0]        rem_t, trial, rem_sub;
  logic               sq_ge;
  logic [31:0]        mag;

  function automatic logic signed [31:0] sat50(input logic signed [49:0] x);
    if (x > 50'sd2147483647) begin
      return bbi_pkg::S32_MAX;
    end else if (x < -50'sd2147483648) begin
      return bbi_pkg::S32_MIN;
    end
    return x[31:0];
  endfunction

  // axis 0 is y, axis 1 is x
  assign ax_pos   = axis ? position_x : position_y;
  assign ax_vel   = axis ? velocity_x : velocity_y;
  assign ax_g     = axis ? grav_x : grav_y;
  assign ax_bound = axis ? box_width : box_height;

  assign low           = ax_pos <= $signed({1'b0, ball_radius});
  assign p_plus_r      = {ax_pos[31], ax_pos} + $signed({2'b00, ball_radius});
  assign high          = p_plus_r >= $signed({2'b00, ax_bound});
  assign bound_minus_r = $signed({1'b0, ax_bound}) - $signed({1'b0, ball_radius});
  assign vr_neg        = (ax_vel == bbi_pkg::S32_MIN) ? bbi_pkg::S32_MAX : -ax_vel;
  assign dh_next       = {np_r[31], np_r} - {ax_pos[31], ax_pos};

  assign prod_next = mul_a * mul_b;
  assign prod_ext  = {{16{prod_r[49]}}, prod_r};

  always_comb begin
    case (state)
      bbi_pkg::S_VX_A: scale_base = velocity_x;
      bbi_pkg::S_VY_A: scale_base = velocity_y;
      bbi_pkg::S_PX_A: scale_base = position_x;
      default:         scale_base = position_y;
    endcase
  end

  // base*2^16 + 2^15 + rate*dt, then floor by 2^16
  assign scaled_sum = {{18{scale_base[31]}}, scale_base, 16'h8000} + prod_ext;
  assign scaled_q   = sat50(scaled_sum[65:16]);

  always_comb begin
    if (acc > bbi_pkg::GD_LIMIT) begin
      acc_cl = bbi_pkg::GD_LIMIT;
    end else if (acc < -bbi_pkg::GD_LIMIT) begin
      acc_cl = -bbi_pkg::GD_LIMIT;
    end else begin
      acc_cl = acc;
    end
  end

  assign rem_t   = {rem, rad[63:62]};
  assign trial   = {2'b00, root, 2'b01};
  assign sq_ge   = rem_t >= trial;
  assign rem_sub = rem_t - trial;

  assign mag    = root[31] ? 32'h7fffffff : root;
  assign vel_wb = (vr_r > 0 || (vr_r == 0 && low_r)) ? $signed(mag) : -$signed(mag);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bbi_pkg::S_IDLE: if (step_valid) state_next = bbi_pkg::S_VX_M;
      bbi_pkg::S_VX_M: state_next = bbi_pkg::S_VX_A;
      bbi_pkg::S_VX_A: state_next = bbi_pkg::S_VY_M;
      bbi_pkg::S_VY_M: state_next = bbi_pkg::S_VY_A;
      bbi_pkg::S_VY_A: state_next = bbi_pkg::S_PX_M;
      bbi_pkg::S_PX_M: state_next = bbi_pkg::S_PX_A;
      bbi_pkg::S_PX_A: state_next = bbi_pkg::S_PY_M;
      bbi_pkg::S_PY_M: state_next = bbi_pkg::S_PY_A;
      bbi_pkg::S_PY_A: state_next = bbi_pkg::S_CHK;
      bbi_pkg::S_CHK: begin
        if (low || high) begin
          state_next = bbi_pkg::S_DH;
        end else if (axis) begin
          state_next = bbi_pkg::S_OUT;
        end
      end
      bbi_pkg::S_DH:  state_next = bbi_pkg::S_M0;
      bbi_pkg::S_M0:  state_next = bbi_pkg::S_M1;
      bbi_pkg::S_M1:  state_next = bbi_pkg::S_A1;
      bbi_pkg::S_A1:  state_next = bbi_pkg::S_CL;
      bbi_pkg::S_CL:  state_next = bbi_pkg::S_M3;
      bbi_pkg::S_M3:  state_next = bbi_pkg::S_A3;
      bbi_pkg::S_A3:  state_next = bbi_pkg::S_SQI;
      bbi_pkg::S_SQI: state_next = bbi_pkg::S_SQ;
      bbi_pkg::S_SQ:  if (sq_cnt == '0) state_next = bbi_pkg::S_WB;
      bbi_pkg::S_WB:  state_next = axis ? bbi_pkg::S_OUT : bbi_pkg::S_CHK;
      bbi_pkg::S_OUT: if (out_load) state_next = bbi_pkg::S_IDLE;
      default:        state_next = bbi_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and multiplier operands
  always_comb begin
    step_stall = state != bbi_pkg::S_IDLE;
    out_load   = (state == bbi_pkg::S_OUT) && (!result_valid || !result_stall);
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      bbi_pkg::S_VX_M: begin
        mul_a = grav_x;
        mul_b = $signed({2'b00, dt_r});
      end
      bbi_pkg::S_VY_M: begin
        mul_a = grav_y;
        mul_b = $signed({2'b00, dt_r});
      end
      bbi_pkg::S_PX_M: begin
        mul_a = velocity_x;
        mul_b = $signed({2'b00, dt_r});
      end
      bbi_pkg::S_PY_M: begin
        mul_a = velocity_y;
        mul_b = $signed({2'b00, dt_r});
      end
      bbi_pkg::S_M0: begin
        mul_a = ax_g;
        mul_b = $signed({1'b0, dh_r[16:0]});
      end
      bbi_pkg::S_M1: begin
        mul_a = ax_g;
        mul_b = {{2{dh_r[32]}}, dh_r[32:17]};
      end
      bbi_pkg::S_CL: begin
        mul_a = vr_r;
        mul_b = $signed({1'b0, vr_r[16:0]});
      end
      bbi_pkg::S_M3: begin
        mul_a = vr_r;
        mul_b = {{3{vr_r[31]}}, vr_r[31:17]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbi_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath without reset
  always_ff @(posedge clk) begin
    prod_r <= prod_next;
    case (state)
      bbi_pkg::S_IDLE: dt_r <= step_time;
      bbi_pkg::S_CHK: begin
        low_r <= low;
        np_r  <= low ? $signed({1'b0, ball_radius}) : bound_minus_r;
        vr_r  <= vr_neg;
      end
      bbi_pkg::S_DH: dh_r <= dh_next;
      bbi_pkg::S_M1: acc  <= prod_ext;
      bbi_pkg::S_A1: acc  <= acc + (prod_ext <<< 17);
      bbi_pkg::S_CL: acc  <= acc_cl <<< 1;
      bbi_pkg::S_M3: acc  <= acc + prod_ext;
      bbi_pkg::S_A3: acc  <= acc + (prod_ext <<< 17);
      bbi_pkg::S_SQI: begin
        rad    <= acc[65] ? 64'd0 : acc[63:0];
        rem    <= '0;
        root   <= '0;
        sq_cnt <= bbi_pkg::SQ_LAST;
      end
      bbi_pkg::S_SQ: begin
        rem    <= sq_ge ? rem_sub[33:0] : rem_t[33:0];
        root   <= {root[30:0], sq_ge};
        rad    <= {rad[61:0], 2'b00};
        sq_cnt <= sq_cnt - 5'd1;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      pos_x <= position_x;
      pos_y <= position_y;
      vel_x <= velocity_x;
      vel_y <= velocity_y;
      hit_x <= hit_x_r;
      hit_y <= hit_y_r;
    end
  end

  // ball state, configuration and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      grav_x       <= bbi_pkg::GRAV_RESET;
      grav_y       <= bbi_pkg::GRAV_RESET;
      box_width    <= bbi_pkg::BOX_WIDTH_RESET;
      box_height   <= bbi_pkg::BOX_HEIGHT_RESET;
      ball_radius  <= bbi_pkg::RADIUS_RESET;
      position_x   <= bbi_pkg::START_X_RESET;
      position_y   <= bbi_pkg::START_Y_RESET;
      velocity_x   <= bbi_pkg::VEL_X_RESET;
      velocity_y   <= bbi_pkg::VEL_Y_RESET;
      axis         <= 1'b0;
      hit_x_r      <= 1'b0;
      hit_y_r      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      case (state)
        bbi_pkg::S_VX_A: velocity_x <= scaled_q;
        bbi_pkg::S_VY_A: velocity_y <= scaled_q;
        bbi_pkg::S_PX_A: position_x <= scaled_q;
        bbi_pkg::S_PY_A: begin
          position_y <= scaled_q;
          axis       <= 1'b0;
        end
        bbi_pkg::S_CHK: begin
          if (axis) begin
            hit_x_r <= low || high;
          end else begin
            hit_y_r <= low || high;
          end
          if (!(low || high)) axis <= 1'b1;
        end
        bbi_pkg::S_WB: begin
          if (axis) begin
            position_x <= np_r;
            velocity_x <= vel_wb;
          end else begin
            position_y <= np_r;
            velocity_y <= vel_wb;
          end
          axis <= 1'b1;
        end
        default: begin
        end
      endcase

      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          bbi_pkg::REG_GRAV_X:      grav_x      <= $signed(cfg_data);
          bbi_pkg::REG_GRAV_Y:      grav_y      <= $signed(cfg_data);
          bbi_pkg::REG_BOX_WIDTH:   box_width   <= cfg_data[30:0];
          bbi_pkg::REG_BOX_HEIGHT:  box_height  <= cfg_data[30:0];
          bbi_pkg::REG_BALL_RADIUS: ball_radius <= cfg_data[30:0];
          bbi_pkg::REG_START_X:     position_x  <= $signed({1'b0, cfg_data[30:0]});
          bbi_pkg::REG_START_Y:     position_y  <= $signed({1'b0, cfg_data[30:0]});
          default: begin
          end
        endcase
      end
    end
  end

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (step_valid && !step_stall) |=> (state == bbi_pkg::S_VX_M))
    else $error("accepted step did not start the sequence");

  a_sqrt_ends: assert property (@(posedge clk) disable iff (rst)
    (state == bbi_pkg::S_SQ && sq_cnt == '0) |=> (state == bbi_pkg::S_WB))
    else $error("square root did not end after its last step");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == bbi_pkg::S_OUT))
    else $error("result loaded outside the output state");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != bbi_pkg::S_IDLE && state != bbi_pkg::S_OUT) |=> step_stall)
    else $error("step channel opened while a step is in work");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for ball_bounce_integrator: directed table, then random steps vs predictor.
module testbench;

  typedef logic signed [65:0] wide_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               hx;
    logic               hy;
  } ball_state_t;

  typedef struct {
    logic        is_cfg;
    logic [2:0]  idx;
    logic [31:0] value;
    logic [15:0] dt;
    logic        known;
    ball_state_t want;
  } stim_row_t;

  localparam int ONE = 65536;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam wide_t GD_CLAMP = 66'sd2305843009213693952;
  localparam int RUN_LIMIT = 1500000;
  localparam int STEPS_PER_PHASE = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic step_valid = 1'b0;
  logic step_stall;
  logic [15:0] step_time = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
  logic hit_x, hit_y;

  ball_bounce_integrator uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .step_valid(step_valid), .step_stall(step_stall), .step_time(step_time),
    .result_valid(result_valid), .result_stall(result_stall),
    .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
    .hit_x(hit_x), .hit_y(hit_y)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mirror of the block's registers and ball state
  logic signed [31:0] g_x = 0;
  logic signed [31:0] g_y = 0;
  logic [30:0] box_w = 31'(800 * ONE);
  logic [30:0] box_h = 31'(600 * ONE);
  logic [30:0] radius = 31'(10 * ONE);
  logic [30:0] st_x = 31'(100 * ONE);
  logic [30:0] st_y = 31'(100 * ONE);
  logic signed [31:0] ball_px = 100 * ONE;
  logic signed [31:0] ball_py = 100 * ONE;
  logic signed [31:0] ball_vx = 20 * ONE;
  logic signed [31:0] ball_vy = 0;

  ball_state_t ball_states_due[$];
  ball_state_t due_now;
  stim_row_t directed[$];
  logic [31:0] cfg_plan[7];
  logic [31:0] extremes[4] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff};
  int phase_kind[7] = '{0, 2, 0, 1, 3, 0, 0};

  int errors = 0;
  int steps_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int hits_x_seen = 0;
  int hits_y_seen = 0;
  int burst_left = 0;
  int hold_left = 0;
  int seg_left = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  function automatic logic signed [31:0] sat_s32(wide_t x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // base + rate*dt, product rounded half up to Q16.16
  function automatic logic signed [31:0] euler_add(logic signed [31:0] base,
                                                   logic signed [31:0] rate,
                                                   logic [15:0] dt);
    wide_t b, r, d;
    b = base;
    r = rate;
    d = dt;
    return sat_s32(b + ((r * d + 32768) >>> 16));
  endfunction

  function automatic logic [32:0] root_floor(logic [65:0] n);
    logic [32:0] res, trial;
    logic [65:0] sq;
    res = '0;
    for (int i = 32; i >= 0; i--) begin
      trial = res | (33'd1 << i);
      sq = trial * trial;
      if (sq <= n) res = trial;
    end
    return res;
  endfunction

  task automatic wall_bounce(inout logic signed [31:0] p, inout logic signed [31:0] v,
                             input logic signed [31:0] g, input logic [30:0] wall,
                             input logic [30:0] r, output logic hit);
    wide_t pw, rw, bw, vw, gw, np, dh, vr, gd, arg;
    logic lo, hi;
    logic [32:0] mag;
    pw = p;
    rw = r;
    bw = wall;
    lo = (pw - rw) <= 0;
    hi = (pw + rw) >= bw;
    hit = lo | hi;
    if (hit) begin
      // low wall wins when both are touched
      np = lo ? rw : bw - rw;
      dh = np - pw;
      vw = v;
      vr = sat_s32(-vw);
      gw = g;
      gd = gw * dh;
      if (gd > GD_CLAMP) gd = GD_CLAMP;
      if (gd < -GD_CLAMP) gd = -GD_CLAMP;
      arg = 2 * gd + vr * vr;
      if (arg < 0) arg = 0;
      mag = root_floor(arg);
      if (mag > 33'd2147483647) mag = 33'd2147483647;
      p = np[31:0];
      v = (vr > 0 || (vr == 0 && lo)) ? mag[31:0] : -mag[31:0];
    end
  endtask

  task automatic advance_ball(input logic [15:0] dt, output ball_state_t res);
    logic hx, hy;
    ball_vx = euler_add(ball_vx, g_x, dt);
    ball_vy = euler_add(ball_vy, g_y, dt);
    ball_px = euler_add(ball_px, ball_vx, dt);
    ball_py = euler_add(ball_py, ball_vy, dt);
    wall_bounce(ball_py, ball_vy, g_y, box_h, radius, hy);
    wall_bounce(ball_px, ball_vx, g_x, box_w, radius, hx);
    res.px = ball_px;
    res.py = ball_py;
    res.vx = ball_vx;
    res.vy = ball_vy;
    res.hx = hx;
    res.hy = hy;
  endtask

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] value);
    case (idx)
      bbi_pkg::REG_GRAV_X:      g_x = value;
      bbi_pkg::REG_GRAV_Y:      g_y = value;
      bbi_pkg::REG_BOX_WIDTH:   box_w = value[30:0];
      bbi_pkg::REG_BOX_HEIGHT:  box_h = value[30:0];
      bbi_pkg::REG_BALL_RADIUS: radius = value[30:0];
      bbi_pkg::REG_START_X: begin
        st_x = value[30:0];
        ball_px = {1'b0, value[30:0]};
      end
      bbi_pkg::REG_START_Y: begin
        st_y = value[30:0];
        ball_py = {1'b0, value[30:0]};
      end
      default: ;
    endcase
  endfunction

  function automatic void row_step(logic [15:0] dt);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.idx = bbi_pkg::REG_GRAV_X;
    r.value = '0;
    r.dt = dt;
    r.known = 1'b0;
    r.want = '0;
    directed.push_back(r);
  endfunction

  function automatic void row_cfg(logic [2:0] idx, logic [31:0] value);
    stim_row_t r;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.value = value;
    r.dt = '0;
    r.known = 1'b0;
    r.want = '0;
    directed.push_back(r);
  endfunction

  function automatic logic [15:0] pick_dt();
    case ($urandom_range(0, 9))
      6, 7:    return 16'($urandom_range(0, 65535));
      8:       return 16'h0000;
      9:       return 16'hffff;
      default: return 16'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic send_step(input logic [15:0] dt, input logic known, input ball_state_t typed);
    ball_state_t stepped;
    int gap;
    if (burst_left == 0) begin
      step_valid <= 1'b0;
      gap = $urandom_range(1, 30);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    step_valid <= 1'b1;
    step_time <= dt;
    @(posedge clk);
    while (step_stall) @(posedge clk);
    advance_ball(dt, stepped);
    ball_states_due.push_back(known ? typed : stepped);
    burst_left--;
    steps_sent++;
  endtask

  // registers change only with the block idle
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    step_valid <= 1'b0;
    while (ball_states_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, value);
    reg_writes++;
  endtask

  // result checking and receiver stall pattern
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (ball_states_due.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing expected, pos_x %0d", $time, pos_x);
      end else begin
        due_now = ball_states_due.pop_front();
        check_field("pos_x", due_now.px, pos_x);
        check_field("pos_y", due_now.py, pos_y);
        check_field("vel_x", due_now.vx, vel_x);
        check_field("vel_y", due_now.vy, vel_y);
        check_field("hit_x", {31'b0, due_now.hx}, {31'b0, hit_x});
        check_field("hit_y", {31'b0, due_now.hy}, {31'b0, hit_y});
        hits_x_seen += due_now.hx;
        hits_y_seen += due_now.hy;
        results_seen++;
        if (results_seen == 300 || results_seen == 1100) hold_left = 320;
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 200);
        case ($urandom_range(0, 3))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 30;
          default: stall_pct = 80;
        endcase
      end
      seg_left--;
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, ball_states_due.size());
      $display("ball_bounce_integrator regression: fail");
      $finish;
    end
  end

  initial begin
    row_step(16'h0000);
    directed[0].known = 1'b1;
    directed[0].want.px = 100 * ONE;
    directed[0].want.py = 100 * ONE;
    directed[0].want.vx = 20 * ONE;
    directed[0].want.vy = 0;
    directed[0].want.hx = 1'b0;
    directed[0].want.hy = 1'b0;
    // resting below radius with zero velocity, pushed up by gravity
    row_cfg(bbi_pkg::REG_START_Y, 5 * ONE);
    row_cfg(bbi_pkg::REG_GRAV_Y, ONE);
    row_step(16'h0000);
    // floor hit where the root argument goes negative
    row_cfg(bbi_pkg::REG_GRAV_Y, -32'sd642253);
    row_cfg(bbi_pkg::REG_START_Y, 0);
    row_step(16'h0000);
    row_step(16'hffff);
    row_step(16'h0001);
    // stop x, then zero velocity at the right wall
    row_cfg(bbi_pkg::REG_GRAV_X, -40 * ONE);
    row_step(16'h8000);
    row_cfg(bbi_pkg::REG_START_X, 795 * ONE);
    row_step(16'h0000);
    row_cfg(bbi_pkg::REG_GRAV_X, 32'h7fffffff);
    row_step(16'hffff);
    row_step(16'hffff);
    row_cfg(bbi_pkg::REG_GRAV_X, 32'h80000000);
    row_step(16'hffff);
    row_step(16'hffff);
    // radius beyond half the box: both walls touched
    row_cfg(bbi_pkg::REG_GRAV_X, 0);
    row_cfg(bbi_pkg::REG_GRAV_Y, 0);
    row_cfg(bbi_pkg::REG_BALL_RADIUS, 700 * ONE);
    row_step(16'h0100);
    row_cfg(bbi_pkg::REG_BALL_RADIUS, 0);
    row_cfg(bbi_pkg::REG_START_X, 0);
    row_cfg(bbi_pkg::REG_START_Y, 0);
    row_step(16'h0000);
    row_cfg(bbi_pkg::REG_BOX_WIDTH, 32'h7fffffff);
    row_cfg(bbi_pkg::REG_BOX_HEIGHT, 32'h7fffffff);
    row_cfg(bbi_pkg::REG_START_X, 32'hffffffff);
    row_cfg(bbi_pkg::REG_START_Y, 32'h7fffffff);
    row_step(16'h0000);
    row_cfg(bbi_pkg::REG_BOX_WIDTH, 0);
    row_cfg(bbi_pkg::REG_BOX_HEIGHT, 0);
    row_step(16'h1234);
    row_cfg(REG_UNUSED, 32'hffffffff);
    row_step(16'hffff);
    row_cfg(bbi_pkg::REG_BOX_WIDTH, 800 * ONE);
    row_cfg(bbi_pkg::REG_BOX_HEIGHT, 600 * ONE);
    row_cfg(bbi_pkg::REG_BALL_RADIUS, 10 * ONE);
    row_cfg(bbi_pkg::REG_GRAV_Y, -32'sd642253);
    row_cfg(bbi_pkg::REG_START_X, 100 * ONE);
    row_cfg(bbi_pkg::REG_START_Y, 100 * ONE);
    row_step(16'h0444);
    row_step(16'h0aaa);
    row_step(16'h5555);
    row_step(16'haaaa);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_reg(directed[i].idx, directed[i].value);
      else send_step(directed[i].dt, directed[i].known, directed[i].want);
    end

    for (int ph = 0; ph < 7; ph++) begin
      case (phase_kind[ph])
        0: begin
          cfg_plan[bbi_pkg::REG_GRAV_X] = $urandom_range(0, 600 * ONE) - 300 * ONE;
          cfg_plan[bbi_pkg::REG_GRAV_Y] = -$urandom_range(0, 600 * ONE);
          cfg_plan[bbi_pkg::REG_BOX_WIDTH] = $urandom_range(100 * ONE, 1000 * ONE);
          cfg_plan[bbi_pkg::REG_BOX_HEIGHT] = $urandom_range(100 * ONE, 1000 * ONE);
          cfg_plan[bbi_pkg::REG_BALL_RADIUS] = $urandom_range(0, 30 * ONE);
          cfg_plan[bbi_pkg::REG_START_X] =
            $urandom_range(0, cfg_plan[bbi_pkg::REG_BOX_WIDTH]);
          cfg_plan[bbi_pkg::REG_START_Y] =
            $urandom_range(0, cfg_plan[bbi_pkg::REG_BOX_HEIGHT]);
        end
        1: begin
          foreach (cfg_plan[k]) cfg_plan[k] = $urandom;
        end
        2: begin
          foreach (cfg_plan[k]) cfg_plan[k] = extremes[$urandom_range(0, 3)];
        end
        default: begin
          cfg_plan[bbi_pkg::REG_GRAV_X] = $urandom_range(0, 100 * ONE) - 50 * ONE;
          cfg_plan[bbi_pkg::REG_GRAV_Y] = $urandom_range(0, 100 * ONE) - 50 * ONE;
          cfg_plan[bbi_pkg::REG_BOX_WIDTH] = $urandom_range(0, 40 * ONE);
          cfg_plan[bbi_pkg::REG_BOX_HEIGHT] = $urandom_range(0, 40 * ONE);
          cfg_plan[bbi_pkg::REG_BALL_RADIUS] = $urandom_range(0, 30 * ONE);
          cfg_plan[bbi_pkg::REG_START_X] = $urandom_range(0, 50 * ONE);
          cfg_plan[bbi_pkg::REG_START_Y] = $urandom_range(0, 50 * ONE);
        end
      endcase
      for (int k = 0; k < 7; k++) write_reg(3'(k), cfg_plan[k]);
      write_reg(REG_UNUSED, $urandom);
      repeat (STEPS_PER_PHASE) send_step(pick_dt(), 1'b0, '0);
    end

    step_valid <= 1'b0;
    while (ball_states_due.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("steps applied: %0d (%0d directed rows), register writes: %0d",
             steps_sent, directed.size(), reg_writes);
    $display("results checked: %0d, wall hits x/y: %0d/%0d, mismatches: %0d",
             results_seen, hits_x_seen, hits_y_seen, errors);
    if (errors == 0) begin
      $display("ball_bounce_integrator regression: pass");
    end else begin
      $display("ball_bounce_integrator regression: fail");
    end
    $finish;
  end

endmodule

// ===== ball_bounce_integrator.f =====
design/bbi_pkg.sv
design/ball_bounce_integrator.sv
tb/testbench.sv
